/* rtl/particle_grid_deposit_core_assert.svh */
// Assertion macros for the grid deposit core.
`ifndef PARTICLE_GRID_DEPOSIT_CORE_ASSERT_SVH
`define PARTICLE_GRID_DEPOSIT_CORE_ASSERT_SVH
// Check an implication on every clock edge outside reset.
`define PGD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check a next-cycle implication outside reset.
`define PGD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/pgd_pkg.sv */
// ----------------------------------------------------------------------------
// pgd_pkg
// Shared types and constants for the grid deposit core.
// ----------------------------------------------------------------------------
package pgd_pkg;
    localparam int CELLS     = 32768;
    localparam int CELL_W    = $clog2(CELLS);
    localparam int STORE_W   = 48 + 48 + 32;
    localparam int DIVIDEND_W = 33;

    localparam logic CMD_DEPOSIT = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    localparam logic [2:0] REG_SCALE = 3'd0;
    localparam logic [2:0] REG_LOW_X = 3'd1;
    localparam logic [2:0] REG_LOW_Y = 3'd2;
    localparam logic [2:0] REG_LOW_Z = 3'd3;
    localparam logic [2:0] REG_DIM_X = 3'd4;
    localparam logic [2:0] REG_DIM_Y = 3'd5;
    localparam logic [2:0] REG_DIM_Z = 3'd6;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture input item
        logic axis_mul;   // multiply one axis (axis select below)
        logic [1:0] axis; // 0 x, 1 y, 2 z
        logic idx_a;      // index step a: cx*dy + cy, limit
        logic idx_b;      // index step b: (..)*dz + cz
        logic div_start;  // start reciprocal
        logic rd_issue;   // issue store read
        logic rd_take;    // capture store read data
        logic wr_issue;   // write updated cell
        logic clr_issue;  // write zero at clear address
        logic res_load;   // load result register
    } t_cmd;

    typedef struct packed {
        logic ok;         // index valid
        logic is_read;    // item is a read command
        logic div_done;   // reciprocal finished
        logic clr_last;   // clear sweep at last cell
    } t_status;
endpackage

/* rtl/pgd_ram.sv */
// ----------------------------------------------------------------------------
// pgd_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module pgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write or read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/pgd_datapath.sv */
// ----------------------------------------------------------------------------
// pgd_datapath
// Cell index arithmetic, reciprocal divider, cell store and result register.
// ----------------------------------------------------------------------------
module pgd_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pgd_pkg::t_cmd         i_cmd,
    output pgd_pkg::t_status      o_status,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [31:0]           i_cfg_data,
    input  logic                  i_item_cmd,
    input  logic [31:0]           i_pos_x,
    input  logic [31:0]           i_pos_y,
    input  logic [31:0]           i_pos_z,
    input  logic [31:0]           i_density,
    input  logic [14:0]           i_read_cell,
    output logic                  o_in_range,
    output logic [14:0]           o_cell_res,
    output logic [47:0]           o_density_sum,
    output logic [47:0]           o_inverse_sum,
    output logic [31:0]           o_count
);
    import pgd_pkg::*;

    localparam logic [47:0] MAX48 = '1;
    localparam logic [31:0] MAX32 = '1;

    // configuration registers
    logic [31:0] r_scale;
    logic [11:0] r_low_x, r_low_y, r_low_z;
    logic [5:0]  r_dim_x, r_dim_y, r_dim_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= 32'd65536;
            r_low_x <= '0; r_low_y <= '0; r_low_z <= '0;
            r_dim_x <= 6'd32; r_dim_y <= 6'd32; r_dim_z <= 6'd32;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SCALE: r_scale <= i_cfg_data;
                REG_LOW_X: r_low_x <= i_cfg_data[11:0];
                REG_LOW_Y: r_low_y <= i_cfg_data[11:0];
                REG_LOW_Z: r_low_z <= i_cfg_data[11:0];
                REG_DIM_X: r_dim_x <= i_cfg_data[5:0];
                REG_DIM_Y: r_dim_y <= i_cfg_data[5:0];
                REG_DIM_Z: r_dim_z <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // captured item
    logic        r_is_read;
    logic [31:0] r_pos [3];
    logic [31:0] r_rho;
    logic [14:0] r_rcell;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_read <= (i_item_cmd == CMD_READ);
            r_pos[0]  <= i_pos_x;
            r_pos[1]  <= i_pos_y;
            r_pos[2]  <= i_pos_z;
            r_rho     <= i_density;
            r_rcell   <= i_read_cell;
        end
    end

    // one shared 32x32 multiplier, one axis per cycle, then cell coordinate
    logic [31:0] w_mpos;
    logic [11:0] w_low;
    logic [63:0] w_prod;
    logic signed [33:0] w_cell;
    logic signed [33:0] r_c [3];

    always_comb begin
        case (i_cmd.axis)
            2'd0:    begin w_mpos = r_pos[0]; w_low = r_low_x; end
            2'd1:    begin w_mpos = r_pos[1]; w_low = r_low_y; end
            default: begin w_mpos = r_pos[2]; w_low = r_low_z; end
        endcase
        w_prod = {32'd0, w_mpos} * {32'd0, r_scale};
        w_cell = $signed({2'b00, w_prod[63:32]}) - $signed({22'd0, w_low});
        if (w_cell < 0 && w_prod[31:0] != '0) begin
            w_cell = w_cell + 34'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.axis_mul) begin
            r_c[i_cmd.axis] <= w_cell;
        end
    end

    // index in two registered steps; 34-bit coords times small dims
    logic signed [47:0] r_part;
    logic signed [57:0] w_idx;
    logic signed [57:0] r_idx;
    logic [17:0]        w_total;
    logic [17:0]        r_limit;
    logic               w_ok;
    logic [14:0]        w_cell_addr;

    assign w_total = {12'd0, r_dim_x} * {12'd0, r_dim_y} * {12'd0, r_dim_z};
    assign w_idx = 58'(r_part * $signed({1'b0, r_dim_z}))
                 + 58'(r_c[2]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_a) begin
            r_part  <= 48'(r_c[0]) * 48'($signed({1'b0, r_dim_y})) + 48'(r_c[1]);
            r_limit <= (w_total < 18'(CELLS)) ? w_total : 18'(CELLS);
        end
        if (i_cmd.idx_b) begin
            r_idx <= w_idx;
        end
    end

    // validity and cell address
    always_comb begin
        if (r_is_read) begin
            w_ok        = {3'd0, r_rcell} < r_limit;
            w_cell_addr = r_rcell;
        end else begin
            w_ok        = (r_idx >= 0) && (r_idx < $signed({40'd0, r_limit}));
            w_cell_addr = r_idx[14:0];
        end
    end

    // restoring divider: 2^32 / rho, one quotient bit per cycle
    logic [32:0] r_rem;
    logic [32:0] r_quot;
    logic [5:0]  r_div_cnt;
    logic        r_div_busy;
    logic [33:0] w_trial;

    assign w_trial = {r_rem, r_quot[32]} - {2'b00, r_rho};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
        end else if (i_cmd.div_start) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= 6'(DIVIDEND_W);
            r_rem      <= '0;
            r_quot     <= {1'b1, 32'd0};
        end else if (r_div_busy) begin
            if (!w_trial[33]) begin
                r_rem  <= w_trial[32:0];
                r_quot <= {r_quot[31:0], 1'b1};
            end else begin
                r_rem  <= {r_rem[31:0], r_quot[32]};
                r_quot <= {r_quot[31:0], 1'b0};
            end
            r_div_cnt <= r_div_cnt - 6'd1;
            if (r_div_cnt == 6'd1) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    logic [47:0] w_recip;
    assign w_recip = (r_rho == '0) ? MAX48 : {15'd0, r_quot};

    // clear sweep address
    logic [CELL_W-1:0] r_clr_addr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_issue) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // cell store, one packed row per cell
    logic               w_we;
    logic [CELL_W-1:0]  w_addr;
    logic [STORE_W-1:0] w_wdata;
    logic [STORE_W-1:0] w_rdata;
    logic [STORE_W-1:0] r_row;
    logic [48:0]        w_dsum, w_isum;
    logic [47:0]        w_dnew, w_inew;
    logic [31:0]        w_cnew;

    assign w_dsum = {1'b0, r_row[127:80]} + {17'd0, r_rho};
    assign w_isum = {1'b0, r_row[79:32]} + {1'b0, w_recip};
    assign w_dnew = w_dsum[48] ? MAX48 : w_dsum[47:0];
    assign w_inew = w_isum[48] ? MAX48 : w_isum[47:0];
    assign w_cnew = (r_row[31:0] == MAX32) ? MAX32 : r_row[31:0] + 32'd1;

    assign w_we    = i_cmd.wr_issue || i_cmd.clr_issue;
    assign w_addr  = i_cmd.clr_issue ? r_clr_addr : w_cell_addr[CELL_W-1:0];
    assign w_wdata = i_cmd.clr_issue ? '0 : {w_dnew, w_inew, w_cnew};

    pgd_ram #(.WIDTH(STORE_W), .DEPTH(CELLS)) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_take) begin
            r_row <= w_rdata;
        end
    end

    // result register
    logic        r_res_ok;
    logic [14:0] r_res_cell;
    logic [47:0] r_res_d, r_res_i;
    logic [31:0] r_res_c;

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_ok   <= w_ok;
            r_res_cell <= w_cell_addr;
            if (!w_ok) begin
                r_res_d <= '0; r_res_i <= '0; r_res_c <= '0;
            end else if (r_is_read) begin
                r_res_d <= r_row[127:80];
                r_res_i <= r_row[79:32];
                r_res_c <= r_row[31:0];
            end else begin
                r_res_d <= w_dnew;
                r_res_i <= w_inew;
                r_res_c <= w_cnew;
            end
        end
    end

    assign o_in_range    = r_res_ok;
    assign o_cell_res    = r_res_cell;
    assign o_density_sum = r_res_d;
    assign o_inverse_sum = r_res_i;
    assign o_count       = r_res_c;

    assign o_status.ok       = w_ok;
    assign o_status.is_read  = r_is_read;
    assign o_status.div_done = !r_div_busy;
    assign o_status.clr_last = (r_clr_addr == CELL_W'(CELLS - 1));
endmodule

/* rtl/pgd_ctrl.sv */
// ----------------------------------------------------------------------------
// pgd_ctrl
// Sequencer: store clear after reset, then one item at a time.
// ----------------------------------------------------------------------------
`include "particle_grid_deposit_core_assert.svh"
module pgd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    input  pgd_pkg::t_status i_status,
    output pgd_pkg::t_cmd    o_cmd
);
    import pgd_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_MX    = 10'b0000000100,
        S_MY    = 10'b0000001000,
        S_MZ    = 10'b0000010000,
        S_IDXA  = 10'b0000100000,
        S_IDXB  = 10'b0001000000,
        S_READ  = 10'b0010000000,
        S_WAIT  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    // take input only in idle; a waiting result holds the next item in done
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_issue = 1'b1;
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MX;
                end
            end
            S_MX: begin
                o_cmd.axis_mul  = 1'b1;
                o_cmd.axis      = 2'd0;
                o_cmd.div_start = 1'b1;
                n_state         = S_MY;
            end
            S_MY: begin
                o_cmd.axis_mul = 1'b1;
                o_cmd.axis     = 2'd1;
                n_state        = S_MZ;
            end
            S_MZ: begin
                o_cmd.axis_mul = 1'b1;
                o_cmd.axis     = 2'd2;
                n_state        = S_IDXA;
            end
            S_IDXA: begin
                o_cmd.idx_a = 1'b1;
                n_state     = S_IDXB;
            end
            S_IDXB: begin
                o_cmd.idx_b    = 1'b1;
                n_state        = S_READ;
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_WAIT;
            end
            S_WAIT: begin
                o_cmd.rd_take = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                // finish when divider is done (or item is a read) and output slot is free
                if ((i_status.div_done || i_status.is_read) && !n_out_valid) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.wr_issue = i_status.ok && !i_status.is_read;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `PGD_ASSERT_IMP(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state), "state not one-hot")
    `PGD_ASSERT_NEXT(a_load_busy, i_clk, i_rst_n, w_accept, !o_s_tready,
        "item taken while busy")
    `PGD_ASSERT_IMP(a_wr_ok, i_clk, i_rst_n, o_cmd.wr_issue, i_status.ok && !i_status.is_read,
        "store write without valid deposit")
    `PGD_ASSERT_NEXT(a_res_valid, i_clk, i_rst_n, o_cmd.res_load, o_m_tvalid,
        "result loaded but not shown")
endmodule

/* rtl/particle_grid_deposit_core.sv */
// ----------------------------------------------------------------------------
// particle_grid_deposit_core
// Nearest-grid-point deposit of particles into a local 3D cell store.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload
//  s_axis   in   tdata: cmd, pos_x, pos_y, pos_z, density, read_cell
//  m_axis   out  tdata: in_range, cell_res, density_sum, inverse_sum, count
//  cfg      in   we, idx (3 bits), data (32 bits)
//
// A deposit waits for the 33-step reciprocal divider before its result and
// the next acceptance; a read does not. After reset the store is cleared
// one cell a cycle, all 32768 cells; no item is taken until then. The
// result sits in an output register; the next item is taken while it
// waits and stalls at its final step until the result is taken.
module particle_grid_deposit_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cmd[0], pos_x[32:1], pos_y[64:33], pos_z[96:65], density[128:97],
    // read_cell[143:129], zero pad [151:144]
    input  logic [151:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // in_range[0], cell_res[15:1], density_sum[63:16], inverse_sum[111:64],
    // count[143:112]
    output logic [143:0] m_axis_tdata
);
    import pgd_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    pgd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_axis_tvalid),
        .o_s_tready(s_axis_tready),
        .o_m_tvalid(m_axis_tvalid),
        .i_m_tready(m_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    pgd_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_item_cmd   (s_axis_tdata[0]),
        .i_pos_x      (s_axis_tdata[32:1]),
        .i_pos_y      (s_axis_tdata[64:33]),
        .i_pos_z      (s_axis_tdata[96:65]),
        .i_density    (s_axis_tdata[128:97]),
        .i_read_cell  (s_axis_tdata[143:129]),
        .o_in_range   (m_axis_tdata[0]),
        .o_cell_res   (m_axis_tdata[15:1]),
        .o_density_sum(m_axis_tdata[63:16]),
        .o_inverse_sum(m_axis_tdata[111:64]),
        .o_count      (m_axis_tdata[143:112])
    );
endmodule

/* sim/grid_deposit_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_deposit_checker
// Watches the configuration port and both stream channels of the grid
// deposit core. It keeps a shadow of the cell store, predicts the result of
// every accepted transaction and compares it field by field.
// ----------------------------------------------------------------------------
module grid_deposit_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [151:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [143:0] m_axis_tdata,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_results,
    output int           o_out_of_range
);
    import pgd_pkg::*;

    localparam logic [47:0] SAT48 = {48{1'b1}};
    localparam logic [31:0] SAT32 = {32{1'b1}};

    // fields from the highest bit down, so in_range lands in bit 0
    typedef struct packed {
        logic [31:0] count;
        logic [47:0] inverse_sum;
        logic [47:0] density_sum;
        logic [14:0] cell_idx;
        logic        in_range;
    } t_cell_result;

    // shadow of the core's registers and store
    logic [31:0] scale_q;
    logic [11:0] low_q [3];
    logic [5:0]  dim_q [3];
    logic [47:0] dens_mem [CELLS];
    logic [47:0] inv_mem  [CELLS];
    logic [31:0] cnt_mem  [CELLS];

    t_cell_result cell_result_q[$];

    assign o_pending = cell_result_q.size();

    // truncate (pos*scale / 2^32 - low) toward zero
    function automatic longint axis_cell(logic [31:0] pos, logic [11:0] low);
        logic [63:0] prod;
        longint      d;
        prod = 64'(pos) * 64'(scale_q);
        d = longint'(prod[63:32]) - longint'(low);
        if (d < 0 && prod[31:0] != 0) d = d + 1;
        return d;
    endfunction

    function automatic logic [47:0] add_sat48(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = a + b;
        return s[48] ? SAT48 : s[47:0];
    endfunction

    // apply one transaction to the shadow store and return its result
    function automatic t_cell_result deposit_or_read(logic [151:0] d);
        t_cell_result r;
        longint       lim, idx;
        logic [31:0]  rho;
        logic [47:0]  recip;
        bit           ok;
        lim = longint'(dim_q[0]) * longint'(dim_q[1]) * longint'(dim_q[2]);
        if (lim > CELLS) lim = CELLS;
        if (d[0] == CMD_READ) begin
            idx = longint'(d[143:129]);
            ok = idx < lim;
        end else begin
            idx = axis_cell(d[32:1], low_q[0]) * (longint'(dim_q[1]) * longint'(dim_q[2]))
                + axis_cell(d[64:33], low_q[1]) * longint'(dim_q[2])
                + axis_cell(d[96:65], low_q[2]);
            ok = idx >= 0 && idx < lim;
            if (ok) begin
                rho = d[128:97];
                recip = (rho == 0) ? SAT48 : 48'((64'd1 << 32) / 64'(rho));
                dens_mem[idx] = add_sat48(dens_mem[idx], 48'(rho));
                inv_mem[idx]  = add_sat48(inv_mem[idx], recip);
                if (cnt_mem[idx] != SAT32) cnt_mem[idx] = cnt_mem[idx] + 1;
            end
        end
        r = '0;
        r.in_range = ok;
        r.cell_idx = idx[14:0];
        if (ok) begin
            r.density_sum = dens_mem[idx];
            r.inverse_sum = inv_mem[idx];
            r.count = cnt_mem[idx];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_cell_result got, want;
        if (!i_rst_n) begin
            scale_q <= 32'd65536;
            for (int a = 0; a < 3; a++) begin
                low_q[a] <= '0;
                dim_q[a] <= 6'd32;
            end
            for (int c = 0; c < CELLS; c++) begin
                dens_mem[c] = '0;
                inv_mem[c]  = '0;
                cnt_mem[c]  = '0;
            end
            cell_result_q.delete();
            o_fail_count <= 0;
            o_results <= 0;
            o_out_of_range <= 0;
        end else begin
            // track register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SCALE: scale_q  <= i_cfg_data;
                    REG_LOW_X: low_q[0] <= i_cfg_data[11:0];
                    REG_LOW_Y: low_q[1] <= i_cfg_data[11:0];
                    REG_LOW_Z: low_q[2] <= i_cfg_data[11:0];
                    REG_DIM_X: dim_q[0] <= i_cfg_data[5:0];
                    REG_DIM_Y: dim_q[1] <= i_cfg_data[5:0];
                    REG_DIM_Z: dim_q[2] <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            // compare an accepted result with the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                o_results <= o_results + 1;
                if (cell_result_q.size() == 0) begin
                    $error("result with no transaction pending: %h", m_axis_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = cell_result_q.pop_front();
                    if (!want.in_range) o_out_of_range <= o_out_of_range + 1;
                    if (got != want) begin
                        o_fail_count <= o_fail_count + 1;
                        if (got.in_range != want.in_range)
                            $error("in_range: expected %0d, got %0d",
                                   want.in_range, got.in_range);
                        if (got.cell_idx != want.cell_idx)
                            $error("cell_res: expected %0d, got %0d",
                                   want.cell_idx, got.cell_idx);
                        if (got.density_sum != want.density_sum)
                            $error("density_sum: expected %h, got %h",
                                   want.density_sum, got.density_sum);
                        if (got.inverse_sum != want.inverse_sum)
                            $error("inverse_sum: expected %h, got %h",
                                   want.inverse_sum, got.inverse_sum);
                        if (got.count != want.count)
                            $error("count: expected %0d, got %0d", want.count, got.count);
                    end
                end
            end
            // predict for an accepted input transaction
            if (s_axis_tvalid && s_axis_tready)
                cell_result_q.push_back(deposit_or_read(s_axis_tdata));
        end
    end
endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the grid deposit core: directed corner particles and reads,
// then random deposits and reads, mostly aimed at the local grid, under
// several register settings and idle/stall patterns. Checking lives in grid_deposit_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import pgd_pkg::*;

    // index past the last register, ignored by the core
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_idx = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;

    int fail_count, pending, results, out_of_range;
    int send_idle_pct = 0;
    int sink_stall_pct = 0;
    int items_sent = 0;

    // current register view used to aim particles
    logic [31:0] cur_scale = 32'd65536;
    logic [11:0] cur_low [3] = '{default: '0};
    logic [5:0]  cur_dim [3] = '{default: 6'd32};

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    particle_grid_deposit_core dut (.*);

    grid_deposit_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .o_fail_count(fail_count), .o_pending(pending),
        .o_results(results), .o_out_of_range(out_of_range)
    );

    // randomly stall the result channel
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SCALE: cur_scale  = val;
            REG_LOW_X: cur_low[0] = val[11:0];
            REG_LOW_Y: cur_low[1] = val[11:0];
            REG_LOW_Z: cur_low[2] = val[11:0];
            REG_DIM_X: cur_dim[0] = val[5:0];
            REG_DIM_Y: cur_dim[1] = val[5:0];
            REG_DIM_Z: cur_dim[2] = val[5:0];
            default: ;
        endcase
    endtask

    // wait for every expected result, then let the core settle
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic send(logic cmd, logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                        logic [31:0] rho, logic [14:0] rd_cell);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {8'h00, rd_cell, rho, pz, py, px, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // position that lands on cell c of an axis, random fraction
    function automatic logic [31:0] aim(int a, int c);
        logic [63:0] q;
        if (cur_scale == 0) return $urandom;
        q = ((64'(c + cur_low[a]) << 32) + 64'($urandom_range(32'hFFFF_FFFF)) % (64'd1 << 32))
            / 64'(cur_scale);
        return (q > 64'hFFFF_FFFF) ? $urandom : q[31:0];
    endfunction

    function automatic logic [31:0] rand_rho();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_items(int n);
        int c[3];
        for (int k = 0; k < n; k++) begin
            for (int a = 0; a < 3; a++)
                c[a] = (cur_dim[a] == 0) ? 0 : $urandom_range(cur_dim[a] - 1);
            case ($urandom_range(9))
                0: send(CMD_READ, $urandom, $urandom, $urandom, $urandom,
                        $urandom_range(1) ? 15'($urandom) : 15'($urandom_range(1200)));
                1: send(CMD_DEPOSIT, $urandom, $urandom, $urandom, $urandom,
                        15'($urandom));
                // hot cell (0,0,0) gets one item in ten so sums climb
                2: send(CMD_DEPOSIT, aim(0, 0), aim(1, 0), aim(2, 0), rand_rho(),
                        15'($urandom));
                default: send(CMD_DEPOSIT, aim(0, c[0]), aim(1, c[1]), aim(2, c[2]),
                              rand_rho(), 15'($urandom));
            endcase
        end
        stop_sending();
    endtask

    task automatic set_idling(int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin send_idle_pct = 56; sink_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  sink_stall_pct = 56; end
            default: begin send_idle_pct = 16; sink_stall_pct = 16; end
        endcase
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corners, saturation seeds, reads
        send(CMD_DEPOSIT, 32'd0, 32'd0, 32'd0, 32'd0, 15'd0);
        send(CMD_DEPOSIT, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 15'h7FFF);
        send(CMD_DEPOSIT, 32'h001F_FFFF, 32'h001F_FFFF, 32'h001F_FFFF, 32'd1, 15'd0);
        send(CMD_DEPOSIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2, 15'd0);
        send(CMD_DEPOSIT, 32'h0020_0000, 32'd0, 32'd0, 32'h0001_0000, 15'd0);
        send(CMD_DEPOSIT, 32'd0, 32'h0020_0000, 32'd0, 32'd3, 15'd0);
        send(CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'd0);
        send(CMD_READ, 32'd0, 32'd0, 32'd0, 32'd0, 15'h7FFF);
        send(CMD_READ, 32'd0, 32'd0, 32'd0, 32'd0, 15'd32767);
        send(CMD_READ, 32'd0, 32'd0, 32'd0, 32'd0, 15'd1);
        stop_sending();
        drain();

        // negative cell between -1 and 0 truncates to 0; -1 or below drops
        write_reg(REG_LOW_X, 32'd5);
        write_reg(REG_LOW_Y, 32'hFFF);
        write_reg(REG_LOW_Z, 32'd1);
        send(CMD_DEPOSIT, 32'h0004_8000, 32'd0, 32'h0000_8000, 32'd7, 15'd0);
        send(CMD_DEPOSIT, 32'h0005_0000, 32'h0FFF_0000, 32'h0001_0000, 32'd7, 15'd0);
        send(CMD_DEPOSIT, 32'd0, 32'd0, 32'd0, 32'd7, 15'd0);
        stop_sending();
        drain();
        // zero dimension invalidates everything; extreme scale
        write_reg(REG_DIM_Y, 32'd0);
        write_reg(REG_SCALE, 32'hFFFF_FFFF);
        send(CMD_DEPOSIT, 32'h0001_0000, 32'd0, 32'd0, 32'd5, 15'd0);
        send(CMD_READ, 32'd0, 32'd0, 32'd0, 32'd0, 15'd0);
        stop_sending();
        drain();
        write_reg(REG_SCALE, 32'd0);
        write_reg(REG_DIM_Y, 32'd63);
        send(CMD_DEPOSIT, $urandom, $urandom, $urandom, 32'd9, 15'd0);
        stop_sending();
        drain();

        // random phases over several register settings
        for (int p = 0; p < 12; p++) begin
            set_idling(p);
            case (p % 6)
                0: begin
                    write_reg(REG_SCALE, 32'd65536);
                    write_reg(REG_LOW_X, 32'd0); write_reg(REG_LOW_Y, 32'd0);
                    write_reg(REG_LOW_Z, 32'd0);
                    write_reg(REG_DIM_X, 32'd32); write_reg(REG_DIM_Y, 32'd32);
                    write_reg(REG_DIM_Z, 32'd32);
                end
                1: begin
                    write_reg(REG_DIM_X, 32'd1); write_reg(REG_DIM_Y, 32'd1);
                    write_reg(REG_DIM_Z, 32'd1);
                end
                2: begin
                    write_reg(REG_SCALE, 32'h0008_0000);
                    write_reg(REG_LOW_X, $urandom_range(4095));
                    write_reg(REG_LOW_Y, $urandom_range(4095));
                    write_reg(REG_LOW_Z, 32'd4095);
                    write_reg(REG_DIM_X, 32'd3); write_reg(REG_DIM_Y, 32'd5);
                    write_reg(REG_DIM_Z, 32'd7);
                end
                3: begin
                    write_reg(REG_SCALE, 32'h0000_4000);
                    write_reg(REG_LOW_X, 32'd0); write_reg(REG_LOW_Y, 32'd0);
                    write_reg(REG_LOW_Z, 32'd0);
                    write_reg(REG_DIM_X, 32'd40); write_reg(REG_DIM_Y, 32'd32);
                    write_reg(REG_DIM_Z, 32'd32);
                end
                4: begin
                    write_reg(REG_SCALE, $urandom);
                    write_reg(REG_DIM_X, $urandom_range(1, 32));
                    write_reg(REG_DIM_Y, $urandom_range(1, 32));
                    write_reg(REG_DIM_Z, $urandom_range(1, 32));
                    write_reg(REG_UNUSED, $urandom);
                end
                default: begin
                    write_reg(REG_SCALE, 32'h0001_8000);
                    write_reg(REG_LOW_X, 32'd2); write_reg(REG_LOW_Y, 32'd1);
                    write_reg(REG_LOW_Z, 32'd3);
                    write_reg(REG_DIM_X, 32'd2); write_reg(REG_DIM_Y, 32'd2);
                    write_reg(REG_DIM_Z, 32'd2);
                end
            endcase
            random_items(54);
            drain();
        end

        $display("Sent %0d transactions, checked %0d results (%0d out of range).",
                 items_sent, results, out_of_range);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // timeout covering the clear sweep plus ~700 items with stalls
    initial begin
        #12_000_000;
        $display("Timeout");
        $display("Some tests failed");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/pgd_pkg.sv
rtl/pgd_ram.sv
rtl/pgd_datapath.sv
rtl/pgd_ctrl.sv
rtl/particle_grid_deposit_core.sv
sim/grid_deposit_checker.sv
sim/tb_top.sv
